// File: rtl/cslca_pkg.sv
// ----------------------------------------------------------------------------
// cslca_pkg: shared types and constants for the color sensor lux / cct block
// Holds the sequencer states, the command structs of the shared units and the
// fixed-point constants of the gain, xyz, lux and cubic cct math.
// ----------------------------------------------------------------------------
`default_nettype none

package cslca_pkg;

  localparam int COUNT_BITS_DEF = 16;

  // widths of the shared units
  localparam int MAC_AW = 41;
  localparam int MAC_BW = 24;
  localparam int ACC_W  = 64;
  localparam int DIV_DW = 64;
  localparam int DIV_VW = 48;
  localparam int DIV_QW = 32;

  // configuration register indexes
  localparam logic [1:0] CFG_ATIME = 2'd0;
  localparam logic [1:0] CFG_CAL   = 2'd1;
  localparam logic [1:0] CFG_GAIN  = 2'd2;

  // reset values
  localparam logic [7:0]  ATIME_RST = 8'd252;
  localparam logic [15:0] CAL_RST   = 16'd256;
  localparam logic [1:0]  GAIN_RST  = 2'd1;

  // threshold: x/10 as (x * 838861) >> 23, exact for x below about 4e6
  localparam logic signed [MAC_BW-1:0] C_THR_HI = 24'sd7549749;
  localparam logic signed [MAC_BW-1:0] C_THR_LO = 24'sd838861;
  localparam int THR_SHIFT = 23;

  // rgb to xyz, q16
  localparam logic signed [MAC_BW-1:0] C_XR = -24'sd9360;
  localparam logic signed [MAC_BW-1:0] C_XG = 24'sd101531;
  localparam logic signed [MAC_BW-1:0] C_XB = -24'sd62679;
  localparam logic signed [MAC_BW-1:0] C_YR = -24'sd21277;
  localparam logic signed [MAC_BW-1:0] C_YG = 24'sd103440;
  localparam logic signed [MAC_BW-1:0] C_YB = -24'sd47966;
  localparam logic signed [MAC_BW-1:0] C_ZR = -24'sd44697;
  localparam logic signed [MAC_BW-1:0] C_ZG = 24'sd50511;
  localparam logic signed [MAC_BW-1:0] C_ZB = 24'sd36918;

  // mccamy ratio terms, scaled by 1e4
  localparam logic signed [MAC_BW-1:0] C_NUM_X = 24'sd10000;
  localparam logic signed [MAC_BW-1:0] C_NUM_S = -24'sd3320;
  localparam logic signed [MAC_BW-1:0] C_DEN_S = 24'sd1858;
  localparam logic signed [MAC_BW-1:0] C_DEN_Y = -24'sd10000;

  // cubic, q16
  localparam logic signed [MAC_AW-1:0] C_N1  = 41'sd447171789;
  localparam logic signed [MAC_AW-1:0] C_N0  = 41'sd361780347;
  localparam logic signed [MAC_BW-1:0] C_N3  = 24'sd449;
  localparam logic signed [MAC_BW-1:0] C_N2  = 24'sd3525;
  localparam logic signed [MAC_BW-1:0] C_ONE = 24'sd1;
  localparam logic signed [ACC_W-1:0]  T_MIN = 64'sd65536000;
  localparam logic signed [ACC_W-1:0]  T_MAX = 64'sd1638400000;
  localparam logic signed [ACC_W-1:0]  T_RND = 64'sd32768;

  // lux normalization
  localparam logic signed [MAC_BW-1:0] C_K        = 24'sd1678476;
  localparam logic signed [MAC_BW-1:0] C_FALLBACK = 24'sd9175;
  localparam logic [DIV_QW-1:0]        Y_MIN_Q8   = 32'd26;
  localparam logic [4:0]               LUX_QBITS  = 5'd30;
  localparam logic [4:0]               CCT_QBITS  = 5'd19;
  localparam logic [4:0]               NORM_SHIFT = 5'd24;

  typedef enum logic [5:0] {
    ST_IDLE, ST_THR_HI, ST_THR_LO,
    ST_X0, ST_X1, ST_X2, ST_Y0, ST_Y1, ST_Y2, ST_Z0, ST_Z1, ST_Z2,
    ST_SUM, ST_NUM0, ST_NUM1, ST_DEN0, ST_DEN1, ST_CHK, ST_CHK2, ST_CDIV,
    ST_N2, ST_N3, ST_M, ST_T0, ST_T1, ST_T2, ST_T3, ST_TCHK,
    ST_L0, ST_L1, ST_LDIV, ST_F0, ST_F1, ST_F2, ST_FDIV, ST_CAL, ST_FIN
  } state_t;

  typedef struct packed {
    logic                     en;
    logic                     accum;
    logic signed [MAC_AW-1:0] a;
    logic signed [MAC_BW-1:0] b;
  } mac_cmd_t;

  typedef struct packed {
    logic              start;
    logic [DIV_DW-1:0] dividend;
    logic [DIV_VW-1:0] divisor;
    logic [4:0]        nbits;
  } div_cmd_t;

  typedef struct packed {
    logic              done;
    logic [DIV_QW-1:0] quotient;
  } div_rsp_t;

  // signed divide by 65536, truncating toward zero
  function automatic logic signed [47:0] trunc16(input logic signed [ACC_W-1:0] p);
    logic signed [ACC_W-1:0] adj;
    adj = p + (p[ACC_W-1] ? 64'sd65535 : 64'sd0);
    return 48'(adj >>> 16);
  endfunction

endpackage

`default_nettype wire

// File: rtl/cslca_mac.sv
// ----------------------------------------------------------------------------
// cslca_mac: shared multiply-accumulate unit
// One signed 41 x 24 multiply per cycle, loaded into or added to a 64-bit
// accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module cslca_mac import cslca_pkg::*; (
  input  wire logic                    clk,
  input  wire mac_cmd_t                cmd,
  output      logic signed [ACC_W-1:0] acc
);

  logic signed [MAC_AW+MAC_BW-1:0] prod;

  assign prod = cmd.a * cmd.b;

  always_ff @(posedge clk) begin
    if (cmd.en) begin
      acc <= (cmd.accum ? acc : '0) + prod[ACC_W-1:0];
    end
  end

endmodule

`default_nettype wire

// File: rtl/cslca_div.sv
// ----------------------------------------------------------------------------
// cslca_div: shared restoring divider
// One quotient bit per cycle; the caller gives the quotient length, and the
// dividend shifted right by it must be below the divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module cslca_div import cslca_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_cmd_t cmd,
  output      div_rsp_t rsp
);

  logic              busy;
  logic [4:0]        cnt;
  logic [4:0]        idx;
  logic [DIV_VW-1:0] rem;
  logic [DIV_VW-1:0] dvs;
  logic [DIV_QW-1:0] dlo;
  logic [DIV_QW-1:0] quo;
  logic              done;
  logic [DIV_VW:0]   trial;
  logic [DIV_VW:0]   shifted;

  assign idx     = cnt - 5'd1;
  assign shifted = {rem, dlo[idx]};
  assign trial   = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        cnt  <= cmd.nbits;
      end else if (busy) begin
        cnt <= idx;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rem <= DIV_VW'(cmd.dividend >> cmd.nbits);
      dvs <= cmd.divisor;
      dlo <= cmd.dividend[DIV_QW-1:0];
      quo <= '0;
    end else if (busy) begin
      if (!trial[DIV_VW]) begin
        rem <= trial[DIV_VW-1:0];
        quo <= {quo[DIV_QW-2:0], 1'b1};
      end else begin
        rem <= shifted[DIV_VW-1:0];
        quo <= {quo[DIV_QW-2:0], 1'b0};
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

`default_nettype wire

// File: rtl/color_sensor_lux_cct_autogain.sv
// ----------------------------------------------------------------------------
// color_sensor_lux_cct_autogain: lux, mccamy cct and auto-gain from rgbc counts
// Sequencer around one shared multiply-accumulate unit and one shared
// bit-serial divider.
// ----------------------------------------------------------------------------
// request to result time is set mostly by the one-bit-per-cycle divider
//   (19 bits for cct, 30 bits per lux division)
// throughput: one request at a time; in_ready is high only while idle, and a
//   new request may be taken while the previous result waits on out_ready
// reset: synchronous, active high; atime 252, calibration 1.0, gain index 1
// ----------------------------------------------------------------------------
`default_nettype none

module color_sensor_lux_cct_autogain import cslca_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // sample request
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic [15:0] red_count,
  input  wire logic [15:0] green_count,
  input  wire logic [15:0] blue_count,
  input  wire logic [15:0] clear_count,
  // result
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic [31:0] lux_q8,
  output      logic [14:0] color_temp_k,
  output      logic        saturated,
  output      logic [1:0]  gain_code,
  output      logic        gain_changed,
  // configuration writes
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  state_t state, state_next;

  // configuration and gain state
  logic [7:0]  atime;
  logic [15:0] cal;
  logic [1:0]  gain_index;

  // latched request, masked to the sensor count width
  logic [COUNT_BITS-1:0] r_q, g_q, b_q, c_q;

  // shared units
  mac_cmd_t                mac_cmd;
  logic signed [ACC_W-1:0] acc;
  div_cmd_t                div_cmd;
  div_rsp_t                div_rsp;

  // working registers
  logic [COUNT_BITS-1:0]    upper, lower;
  logic signed [MAC_AW-1:0] x_q, y_q, s_q;
  logic signed [ACC_W-1:0]  num;
  logic [DIV_VW-1:0]        an, ad;
  logic                     neg;
  logic signed [19:0]       n;
  logic [22:0]              n2;
  logic signed [26:0]       n3;
  logic signed [33:0]       m;
  logic [29:0]              lux_l;
  logic [14:0]              cct_q;
  logic [1:0]               gnext;
  logic                     gchg, gsat;

  // derived values
  logic [8:0]            steps;
  logic [18:0]           ceil_raw;
  logic [COUNT_BITS-1:0] ceiling;
  logic [4:0]            lux_sh;
  logic                  y_pos, s_pos, cct_bad;
  logic                  c_hi, c_lo;
  logic [1:0]            dec_gain;
  logic                  dec_chg;
  logic                  fin_go;

  assign steps    = 9'd256 - {1'b0, atime};
  assign ceil_raw = {steps, 10'b0};
  assign ceiling  = (ceil_raw > 19'(COUNT_MAX)) ? COUNT_MAX : ceil_raw[COUNT_BITS-1:0];
  // normalization shift uses the gain in effect during capture
  assign lux_sh   = NORM_SHIFT + {2'b0, gain_index, 1'b0};
  assign y_pos    = !y_q[MAC_AW-1] && (y_q != '0);
  assign s_pos    = !s_q[MAC_AW-1] && (s_q != '0);
  // outside the ratio band when |n| >= 8
  assign cct_bad  = !s_pos || (ad == '0) || ({3'b0, an} >= {ad, 3'b0});

  // auto-gain: step down on a bright sample, up on a dim one
  assign c_hi = (c_q >= upper);
  assign c_lo = (c_q < lower);
  always_comb begin
    dec_gain = gain_index;
    dec_chg  = 1'b0;
    if (c_hi && gain_index != 2'd0) begin
      dec_gain = gain_index - 2'd1;
      dec_chg  = 1'b1;
    end else if (c_lo && gain_index != 2'd3) begin
      dec_gain = gain_index + 2'd1;
      dec_chg  = 1'b1;
    end
  end

  // result slot frees when empty or taken this cycle
  assign fin_go   = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);

  cslca_mac u_mac (
    .clk (clk),
    .cmd (mac_cmd),
    .acc (acc)
  );

  cslca_div u_div (
    .clk (clk),
    .rst (rst),
    .cmd (div_cmd),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer: next state and shared unit commands
  always_comb begin
    state_next = state;
    mac_cmd    = '0;
    div_cmd    = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_THR_HI;
        end
      end
      ST_THR_HI: begin
        mac_cmd    = '{en: 1'b1, accum: 1'b0, a: 41'(ceiling), b: C_THR_HI};
        state_next = ST_THR_LO;
      end
      ST_THR_LO: begin
        mac_cmd    = '{en: 1'b1, accum: 1'b0, a: 41'(ceiling), b: C_THR_LO};
        state_next = ST_X0;
      end
      ST_X0: begin
        mac_cmd    = '{en: 1'b1, accum: 1'b0, a: 41'(r_q), b: C_XR};
        state_next = ST_X1;
      end
      ST_X1: begin
        mac_cmd    = '{en: 1'b1, accum: 1'b1, a: 41'(g_q), b: C_XG};
        state_next = ST_X2;
      end
      ST_X2: begin
        mac_cmd    = '{en: 1'b1, accum: 1'b1, a: 41'(b_q), b: C_XB};
        state_next = ST_Y0;
      end
      ST_Y0: begin
        mac_cmd    = '{en: 1'b1, accum: 1'b0, a: 41'(r_q), b: C_YR};
        state_next = ST_Y1;
      end
      ST_Y1: begin
        mac_cmd    = '{en: 1'b1, accum: 1'b1, a: 41'(g_q), b: C_YG};
        state_next = ST_Y2;
      end
      ST_Y2: begin
        mac_cmd    = '{en: 1'b1, accum: 1'b1, a: 41'(b_q), b: C_YB};
        state_next = ST_Z0;
      end
      ST_Z0: begin
        mac_cmd    = '{en: 1'b1, accum: 1'b0, a: 41'(r_q), b: C_ZR};
        state_next = ST_Z1;
      end
      ST_Z1: begin
        mac_cmd    = '{en: 1'b1, accum: 1'b1, a: 41'(g_q), b: C_ZG};
        state_next = ST_Z2;
      end
      ST_Z2: begin
        mac_cmd    = '{en: 1'b1, accum: 1'b1, a: 41'(b_q), b: C_ZB};
        state_next = ST_SUM;
      end
      ST_SUM: begin
        state_next = ST_NUM0;
      end
      ST_NUM0: begin
        mac_cmd    = '{en: 1'b1, accum: 1'b0, a: x_q, b: C_NUM_X};
        state_next = ST_NUM1;
      end
      ST_NUM1: begin
        mac_cmd    = '{en: 1'b1, accum: 1'b1, a: s_q, b: C_NUM_S};
        state_next = ST_DEN0;
      end
      ST_DEN0: begin
        mac_cmd    = '{en: 1'b1, accum: 1'b0, a: s_q, b: C_DEN_S};
        state_next = ST_DEN1;
      end
      ST_DEN1: begin
        mac_cmd    = '{en: 1'b1, accum: 1'b1, a: y_q, b: C_DEN_Y};
        state_next = ST_CHK;
      end
      ST_CHK: begin
        state_next = ST_CHK2;
      end
      ST_CHK2: begin
        if (cct_bad) begin
          state_next = ST_L0;
        end else begin
          div_cmd    = '{start: 1'b1, dividend: {an, 16'b0}, divisor: ad, nbits: CCT_QBITS};
          state_next = ST_CDIV;
        end
      end
      ST_CDIV: begin
        if (div_rsp.done) begin
          state_next = ST_N2;
        end
      end
      ST_N2: begin
        mac_cmd    = '{en: 1'b1, accum: 1'b0, a: 41'(n), b: 24'(n)};
        state_next = ST_N3;
      end
      ST_N3: begin
        mac_cmd    = '{en: 1'b1, accum: 1'b0, a: 41'(acc[38:16]), b: 24'(n)};
        state_next = ST_M;
      end
      ST_M: begin
        mac_cmd    = '{en: 1'b1, accum: 1'b0, a: C_N1, b: 24'(n)};
        state_next = ST_T0;
      end
      ST_T0: begin
        mac_cmd    = '{en: 1'b1, accum: 1'b0, a: 41'(n3), b: C_N3};
        state_next = ST_T1;
      end
      ST_T1: begin
        mac_cmd    = '{en: 1'b1, accum: 1'b1, a: 41'(n2), b: C_N2};
        state_next = ST_T2;
      end
      ST_T2: begin
        mac_cmd    = '{en: 1'b1, accum: 1'b1, a: C_N0, b: C_ONE};
        state_next = ST_T3;
      end
      ST_T3: begin
        mac_cmd    = '{en: 1'b1, accum: 1'b1, a: 41'(m), b: C_ONE};
        state_next = ST_TCHK;
      end
      ST_TCHK: begin
        state_next = ST_L0;
      end
      ST_L0: begin
        if (y_pos) begin
          mac_cmd    = '{en: 1'b1, accum: 1'b0, a: y_q, b: C_K};
          state_next = ST_L1;
        end else begin
          state_next = ST_F0;
        end
      end
      ST_L1: begin
        div_cmd    = '{start: 1'b1, dividend: acc >> lux_sh, divisor: 48'(steps),
                       nbits: LUX_QBITS};
        state_next = ST_LDIV;
      end
      ST_LDIV: begin
        if (div_rsp.done) begin
          state_next = (div_rsp.quotient < Y_MIN_Q8) ? ST_F0 : ST_CAL;
        end
      end
      ST_F0: begin
        mac_cmd    = '{en: 1'b1, accum: 1'b0, a: 41'(c_q), b: C_FALLBACK};
        state_next = ST_F1;
      end
      ST_F1: begin
        mac_cmd    = '{en: 1'b1, accum: 1'b0, a: acc[MAC_AW-1:0], b: C_K};
        state_next = ST_F2;
      end
      ST_F2: begin
        div_cmd    = '{start: 1'b1, dividend: acc >> lux_sh, divisor: 48'(steps),
                       nbits: LUX_QBITS};
        state_next = ST_FDIV;
      end
      ST_FDIV: begin
        if (div_rsp.done) begin
          state_next = ST_CAL;
        end
      end
      ST_CAL: begin
        mac_cmd    = '{en: 1'b1, accum: 1'b0, a: 41'(lux_l), b: 24'(cal)};
        state_next = ST_FIN;
      end
      ST_FIN: begin
        if (fin_go) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // configuration and gain index; config writes must come only while idle (the block does not enforce it)
  always_ff @(posedge clk) begin
    if (rst) begin
      atime      <= ATIME_RST;
      cal        <= CAL_RST;
      gain_index <= GAIN_RST;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ATIME: atime      <= cfg_data[7:0];
          CFG_CAL:   cal        <= cfg_data;
          CFG_GAIN:  gain_index <= cfg_data[1:0];
          default:   ;
        endcase
      end
      // new gain takes effect once the result is formed
      if (state == ST_FIN && fin_go) begin
        gain_index <= gnext;
      end
    end
  end

  // result handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FIN && fin_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        r_q <= red_count[COUNT_BITS-1:0];
        g_q <= green_count[COUNT_BITS-1:0];
        b_q <= blue_count[COUNT_BITS-1:0];
        c_q <= clear_count[COUNT_BITS-1:0];
      end
      ST_X0:   lower <= COUNT_BITS'(acc >>> THR_SHIFT);
      ST_THR_LO: upper <= COUNT_BITS'(acc >>> THR_SHIFT);
      ST_Y0:   x_q <= acc[MAC_AW-1:0];
      ST_Z0:   y_q <= acc[MAC_AW-1:0];
      ST_SUM: begin
        s_q   <= x_q + y_q + acc[MAC_AW-1:0];
        gnext <= dec_gain;
        gchg  <= dec_chg;
        gsat  <= c_hi && (dec_gain == 2'd0);
      end
      ST_DEN0: num <= acc;
      ST_CHK: begin
        an  <= num[ACC_W-1] ? DIV_VW'(-num) : num[DIV_VW-1:0];
        ad  <= acc[ACC_W-1] ? DIV_VW'(-acc) : acc[DIV_VW-1:0];
        neg <= num[ACC_W-1] ^ acc[ACC_W-1];
      end
      ST_CHK2: begin
        if (cct_bad) begin
          cct_q <= '0;
        end
      end
      ST_CDIV: begin
        if (div_rsp.done) begin
          n <= neg ? -20'(div_rsp.quotient[18:0]) : 20'(div_rsp.quotient[18:0]);
        end
      end
      ST_N3:   n2 <= acc[38:16];
      ST_M:    n3 <= 27'(trunc16(acc));
      ST_T0:   m  <= 34'(trunc16(acc));
      ST_TCHK: begin
        if (acc >= T_MIN && acc <= T_MAX) begin
          cct_q <= 15'((acc + T_RND) >>> 16);
        end else begin
          cct_q <= '0;
        end
      end
      ST_LDIV, ST_FDIV: begin
        if (div_rsp.done) begin
          lux_l <= div_rsp.quotient[29:0];
        end
      end
      ST_FIN: begin
        if (fin_go) begin
          // q8 calibration, saturating at the top of the 32-bit range
          lux_q8       <= (acc[ACC_W-1:40] != '0) ? '1 : acc[39:8];
          color_temp_k <= cct_q;
          saturated    <= gsat;
          gain_code    <= gnext;
          gain_changed <= gchg;
        end
      end
      default: ;
    endcase
  end

  // saturation is only reported at the lowest gain
  assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> gain_code == 2'd0)
    else $error("saturation flagged above lowest gain");

  // a nonzero cct lies inside the valid band
  assert property (@(posedge clk) disable iff (rst)
    out_valid && color_temp_k != '0 |-> color_temp_k >= 15'd1000 && color_temp_k <= 15'd25000)
    else $error("cct outside valid band");

  // a taken request keeps the block busy on the next cycle
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while a sample is in progress");

endmodule

`default_nettype wire
